/* src/sppc_pkg.sv */
package sppc_pkg;

    localparam int ADC_BITS   = 10;
    localparam int CFG_BITS   = 10;
    localparam int WIDTH_BITS = 11;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // Compare width wide enough for both a sample and a 10-bit register.
    localparam int CMP_BITS  = (ADC_BITS > CFG_BITS) ? ADC_BITS : CFG_BITS;
    localparam int DIFF_BITS = ADC_BITS + 1;
    localparam int WIDE_BITS = ADC_BITS + 4;

    // Divide by five as a multiply by a rounded-up reciprocal; exact for any ADC_BITS input.
    localparam int DIV5_SHIFT = ADC_BITS + 3;
    localparam int PROD_BITS  = ADC_BITS + DIV5_SHIFT;
    localparam logic [DIV5_SHIFT-1:0] DIV5_RECIP = DIV5_SHIFT'(((1 << DIV5_SHIFT) + 4) / 5);

    localparam logic [WIDE_BITS-1:0] CENTER_WIDTH = WIDE_BITS'(1500);
    localparam logic [WIDE_BITS-1:0] DEAD_HIGH    = WIDE_BITS'(1510);
    localparam logic [WIDE_BITS-1:0] DEAD_LOW     = WIDE_BITS'(1490);

    localparam logic [2:0] REG_SAFE_HIGH      = 3'd0;
    localparam logic [2:0] REG_SAFE_LOW       = 3'd1;
    localparam logic [2:0] REG_ARRIVE_TOL     = 3'd2;
    localparam logic [2:0] REG_STILL_TOL      = 3'd3;
    localparam logic [2:0] REG_MIN_FWD_WIDTH  = 3'd4;
    localparam logic [2:0] REG_MIN_BACK_WIDTH = 3'd5;
    localparam logic [2:0] REG_MAX_FWD_WIDTH  = 3'd6;
    localparam logic [2:0] REG_MAX_BACK_WIDTH = 3'd7;

    localparam logic [CFG_BITS-1:0]   RST_SAFE_HIGH      = CFG_BITS'(924);
    localparam logic [CFG_BITS-1:0]   RST_SAFE_LOW       = CFG_BITS'(100);
    localparam logic [CFG_BITS-1:0]   RST_ARRIVE_TOL     = CFG_BITS'(10);
    localparam logic [CFG_BITS-1:0]   RST_STILL_TOL      = CFG_BITS'(5);
    localparam logic [WIDTH_BITS-1:0] RST_MIN_FWD_WIDTH  = WIDTH_BITS'(1550);
    localparam logic [WIDTH_BITS-1:0] RST_MIN_BACK_WIDTH = WIDTH_BITS'(1450);
    localparam logic [WIDTH_BITS-1:0] RST_MAX_FWD_WIDTH  = WIDTH_BITS'(1700);
    localparam logic [WIDTH_BITS-1:0] RST_MAX_BACK_WIDTH = WIDTH_BITS'(1300);

    typedef struct packed {
        logic [ADC_BITS-1:0] pot_sample;
        logic [ADC_BITS-1:0] target_position;
    } sample_t;

    typedef struct packed {
        logic                  write_width;
        logic [WIDTH_BITS-1:0] pulse_width;
        logic                  arrived;
        logic                  safety_stop;
    } result_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]   safe_high;
        logic [CFG_BITS-1:0]   safe_low;
        logic [CFG_BITS-1:0]   arrive_tolerance;
        logic [CFG_BITS-1:0]   still_tolerance;
        logic [WIDTH_BITS-1:0] min_fwd_width;
        logic [WIDTH_BITS-1:0] min_back_width;
        logic [WIDTH_BITS-1:0] max_fwd_width;
        logic [WIDTH_BITS-1:0] max_back_width;
    } cfg_t;

endpackage

/* src/servo_position_p_controller_unit.sv */
// Proportional servo position controller. Each sample beat carries one
// potentiometer reading and a target position in pot counts and yields exactly
// one result beat: a safety stop with the minimum forward or backward width
// when the reading is outside the safe window, an arrival report when the
// reading is within tolerance of both the target and the last stored reading,
// or otherwise a pulse width of 1500 + floor((sample - target) / 5) with a
// minimum-speed lift and clamping, in which case the reading becomes the
// stored position. A beat passes through an input register and a result
// register, taking one beat every cycle unless the result side stalls; the
// only loop is the stored position, written on the edge that loads the next
// beat into the input register. Settings are written through the APB port and
// take effect for any beat that leaves the input register after the write.
module servo_position_p_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sppc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [sppc_pkg::DATA_BITS-1:0]  pwdata,
    output logic [sppc_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  sppc_pkg::sample_t               sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output sppc_pkg::result_t               result
);
    import sppc_pkg::*;

    cfg_t                cfg;
    logic                in_valid_reg;
    sample_t             in_item_reg;
    logic                out_valid_reg;
    result_t             out_item_reg;
    logic [ADC_BITS-1:0] last_pos_reg;
    result_t             calc_result;
    logic                calc_store;
    logic                advance;
    logic                move;
    logic                accept;

    assign pready = 1'b1;

    sppc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    sppc_calc u_calc (
        .cfg           (cfg),
        .item          (in_item_reg),
        .last_position (last_pos_reg),
        .result        (calc_result),
        .store         (calc_store)
    );

    // The result register frees up when it is empty or its beat is taken.
    assign advance      = !out_valid_reg || !result_stall;
    assign move         = in_valid_reg && advance;
    assign sample_stall = in_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_pos_reg  <= '0;
        end
        else
        begin
            if (!sample_stall)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move && calc_store)
            begin
                last_pos_reg <= in_item_reg.pot_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= sample;
        end
        if (move)
        begin
            out_item_reg <= calc_result;
        end
    end

endmodule

/* src/sppc_regs.sv */
module sppc_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sppc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [sppc_pkg::DATA_BITS-1:0]  pwdata,
    output logic [sppc_pkg::DATA_BITS-1:0]  prdata,
    output sppc_pkg::cfg_t                  cfg
);
    import sppc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.safe_high        <= RST_SAFE_HIGH;
            cfg_reg.safe_low         <= RST_SAFE_LOW;
            cfg_reg.arrive_tolerance <= RST_ARRIVE_TOL;
            cfg_reg.still_tolerance  <= RST_STILL_TOL;
            cfg_reg.min_fwd_width    <= RST_MIN_FWD_WIDTH;
            cfg_reg.min_back_width   <= RST_MIN_BACK_WIDTH;
            cfg_reg.max_fwd_width    <= RST_MAX_FWD_WIDTH;
            cfg_reg.max_back_width   <= RST_MAX_BACK_WIDTH;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SAFE_HIGH:      cfg_reg.safe_high        <= pwdata[CFG_BITS-1:0];
                REG_SAFE_LOW:       cfg_reg.safe_low         <= pwdata[CFG_BITS-1:0];
                REG_ARRIVE_TOL:     cfg_reg.arrive_tolerance <= pwdata[CFG_BITS-1:0];
                REG_STILL_TOL:      cfg_reg.still_tolerance  <= pwdata[CFG_BITS-1:0];
                REG_MIN_FWD_WIDTH:  cfg_reg.min_fwd_width    <= pwdata[WIDTH_BITS-1:0];
                REG_MIN_BACK_WIDTH: cfg_reg.min_back_width   <= pwdata[WIDTH_BITS-1:0];
                REG_MAX_FWD_WIDTH:  cfg_reg.max_fwd_width    <= pwdata[WIDTH_BITS-1:0];
                REG_MAX_BACK_WIDTH: cfg_reg.max_back_width   <= pwdata[WIDTH_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SAFE_HIGH:      prdata = DATA_BITS'(cfg_reg.safe_high);
            REG_SAFE_LOW:       prdata = DATA_BITS'(cfg_reg.safe_low);
            REG_ARRIVE_TOL:     prdata = DATA_BITS'(cfg_reg.arrive_tolerance);
            REG_STILL_TOL:      prdata = DATA_BITS'(cfg_reg.still_tolerance);
            REG_MIN_FWD_WIDTH:  prdata = DATA_BITS'(cfg_reg.min_fwd_width);
            REG_MIN_BACK_WIDTH: prdata = DATA_BITS'(cfg_reg.min_back_width);
            REG_MAX_FWD_WIDTH:  prdata = DATA_BITS'(cfg_reg.max_fwd_width);
            REG_MAX_BACK_WIDTH: prdata = DATA_BITS'(cfg_reg.max_back_width);
        endcase
    end

endmodule

/* src/sppc_calc.sv */
module sppc_calc (
    input  sppc_pkg::cfg_t                 cfg,
    input  sppc_pkg::sample_t              item,
    input  logic [sppc_pkg::ADC_BITS-1:0]  last_position,
    output sppc_pkg::result_t              result,
    output logic                           store
);
    import sppc_pkg::*;

    logic [ADC_BITS-1:0]          s;
    logic [ADC_BITS-1:0]          t;
    logic signed [DIFF_BITS-1:0]  err;
    logic                         err_neg;
    logic [ADC_BITS-1:0]          mag;
    logic [PROD_BITS-1:0]         prod;
    logic [ADC_BITS-1:0]          quot;
    logic [WIDE_BITS-1:0]         quot_ext;
    logic signed [WIDE_BITS-1:0]  step;
    logic signed [WIDE_BITS-1:0]  raw_w;
    logic signed [WIDE_BITS-1:0]  lift_w;
    logic signed [WIDE_BITS-1:0]  clamp_w;
    logic signed [WIDE_BITS-1:0]  min_fwd_s;
    logic signed [WIDE_BITS-1:0]  min_back_s;
    logic signed [WIDE_BITS-1:0]  max_fwd_s;
    logic signed [WIDE_BITS-1:0]  max_back_s;
    logic [ADC_BITS-1:0]          dist_target;
    logic [ADC_BITS-1:0]          dist_last;
    logic                         too_high;
    logic                         too_low;
    logic                         at_rest;

    assign s       = item.pot_sample;
    assign t       = item.target_position;
    assign err     = $signed({1'b0, s}) - $signed({1'b0, t});
    assign err_neg = err[DIFF_BITS-1];

    // Floor division: for a negative error, ~err equals -err-1 and the
    // floored quotient is ~(that quotient), so one unsigned divide covers both.
    assign mag      = err_neg ? ~err[ADC_BITS-1:0] : err[ADC_BITS-1:0];
    assign prod     = PROD_BITS'(mag) * PROD_BITS'(DIV5_RECIP);
    assign quot     = prod[PROD_BITS-1:DIV5_SHIFT];
    assign quot_ext = WIDE_BITS'(quot);
    assign step     = err_neg ? $signed(~quot_ext) : $signed(quot_ext);
    assign raw_w    = $signed(CENTER_WIDTH) + step;

    assign min_fwd_s  = $signed(WIDE_BITS'(cfg.min_fwd_width));
    assign min_back_s = $signed(WIDE_BITS'(cfg.min_back_width));
    assign max_fwd_s  = $signed(WIDE_BITS'(cfg.max_fwd_width));
    assign max_back_s = $signed(WIDE_BITS'(cfg.max_back_width));

    always_comb
    begin
        priority if (raw_w < min_fwd_s && raw_w > $signed(DEAD_HIGH))
            lift_w = min_fwd_s;
        else if (raw_w > min_back_s && raw_w < $signed(DEAD_LOW))
            lift_w = min_back_s;
        else
            lift_w = raw_w;

        priority if (lift_w > max_fwd_s)
            clamp_w = max_fwd_s;
        else if (lift_w < max_back_s)
            clamp_w = max_back_s;
        else
            clamp_w = lift_w;
    end

    assign dist_target = (s >= t) ? (s - t) : (t - s);
    assign dist_last   = (s >= last_position) ? (s - last_position) : (last_position - s);

    assign too_high = CMP_BITS'(s) > CMP_BITS'(cfg.safe_high);
    assign too_low  = CMP_BITS'(s) < CMP_BITS'(cfg.safe_low);
    assign at_rest  = (CMP_BITS'(dist_target) <= CMP_BITS'(cfg.arrive_tolerance))
                   && (CMP_BITS'(dist_last) <= CMP_BITS'(cfg.still_tolerance));

    always_comb
    begin
        store = 1'b0;
        priority if (too_high)
        begin
            result.write_width = 1'b1;
            result.pulse_width = cfg.min_fwd_width;
            result.arrived     = 1'b0;
            result.safety_stop = 1'b1;
        end
        else if (too_low)
        begin
            result.write_width = 1'b1;
            result.pulse_width = cfg.min_back_width;
            result.arrived     = 1'b0;
            result.safety_stop = 1'b1;
        end
        else if (at_rest)
        begin
            result.write_width = 1'b0;
            result.pulse_width = '0;
            result.arrived     = 1'b1;
            result.safety_stop = 1'b0;
        end
        else
        begin
            store              = 1'b1;
            result.write_width = 1'b1;
            result.pulse_width = clamp_w[WIDTH_BITS-1:0];
            result.arrived     = 1'b0;
            result.safety_stop = 1'b0;
        end
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sppc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 160;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Mirror of the block's settings and stored position.
    cfg_t                ctl_cfg;
    logic [ADC_BITS-1:0] last_pos;

    sample_t tick_queue[$];
    result_t pending_results[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_ask = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  failures = 0;
    int  gen_smp = 512;
    int  gen_tgt = 512;
    bit  in_taken = 1'b0;

    servo_position_p_controller_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t predict_tick(sample_t s);
        result_t r;
        int smp, tgt, gap, drift, d, q, w;
        int mfw, mbw, xfw, xbw;
        r = '0;
        smp = s.pot_sample;
        tgt = s.target_position;
        mfw = ctl_cfg.min_fwd_width;
        mbw = ctl_cfg.min_back_width;
        xfw = ctl_cfg.max_fwd_width;
        xbw = ctl_cfg.max_back_width;
        gap = (smp > tgt) ? smp - tgt : tgt - smp;
        drift = (int'(last_pos) > smp) ? int'(last_pos) - smp : smp - int'(last_pos);
        if (smp > int'(ctl_cfg.safe_high))
        begin
            r.write_width = 1'b1;
            r.pulse_width = ctl_cfg.min_fwd_width;
            r.safety_stop = 1'b1;
        end
        else if (smp < int'(ctl_cfg.safe_low))
        begin
            r.write_width = 1'b1;
            r.pulse_width = ctl_cfg.min_back_width;
            r.safety_stop = 1'b1;
        end
        else if (gap <= int'(ctl_cfg.arrive_tolerance) && drift <= int'(ctl_cfg.still_tolerance))
        begin
            r.arrived = 1'b1;
        end
        else
        begin
            last_pos = s.pot_sample;
            d = smp - tgt;
            // The divide rounds toward minus infinity.
            q = (d >= 0) ? d / 5 : -((4 - d) / 5);
            w = 1500 + q;
            if (w < mfw && w > 1510)
                w = mfw;
            else if (w > mbw && w < 1490)
                w = mbw;
            if (w > xfw)
                w = xfw;
            else if (w < xbw)
                w = xbw;
            r.write_width = 1'b1;
            r.pulse_width = w[WIDTH_BITS-1:0];
        end
        return r;
    endfunction

    function automatic int clip_count(int v);
        return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
    endfunction

    task automatic push_tick(int smp, int tgt);
        sample_t it;
        it.pot_sample = smp[ADC_BITS-1:0];
        it.target_position = tgt[ADC_BITS-1:0];
        tick_queue.push_back(it);
    endtask

    // Settling runs toward a held target are the largest share, so that arrival and
    // the stillness test get exercised; the rest is random, near-target and boundary noise.
    task automatic push_random_ticks(int count);
        int mode, s, t, lo, hi;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 9);
            lo = ctl_cfg.safe_low;
            hi = ctl_cfg.safe_high;
            t = $urandom_range(0, 1023);
            if (mode < 2)
            begin
                s = $urandom_range(0, 1023);
            end
            else if (mode < 6)
            begin
                t = gen_tgt;
                s = gen_smp + (t - gen_smp) / 2 + int'($urandom_range(0, 8)) - 4;
            end
            else if (mode < 9)
            begin
                s = t + int'($urandom_range(0, 600)) - 300;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: s = hi;
                    1: s = hi + 1;
                    2: s = lo;
                    3: s = lo - 1;
                    4: s = 0;
                    default: s = 1023;
                endcase
            end
            gen_smp = clip_count(s);
            gen_tgt = clip_count(t);
            push_tick(gen_smp, gen_tgt);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [DATA_BITS-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SAFE_HIGH:      ctl_cfg.safe_high = val[CFG_BITS-1:0];
            REG_SAFE_LOW:       ctl_cfg.safe_low = val[CFG_BITS-1:0];
            REG_ARRIVE_TOL:     ctl_cfg.arrive_tolerance = val[CFG_BITS-1:0];
            REG_STILL_TOL:      ctl_cfg.still_tolerance = val[CFG_BITS-1:0];
            REG_MIN_FWD_WIDTH:  ctl_cfg.min_fwd_width = val[WIDTH_BITS-1:0];
            REG_MIN_BACK_WIDTH: ctl_cfg.min_back_width = val[WIDTH_BITS-1:0];
            REG_MAX_FWD_WIDTH:  ctl_cfg.max_fwd_width = val[WIDTH_BITS-1:0];
            default:            ctl_cfg.max_back_width = val[WIDTH_BITS-1:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Holds the test sequence until every queued tick has produced its result,
    // then lets the two-stage pipeline settle.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || sample_valid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || in_taken)
        begin
            if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample <= tick_queue.pop_front();
                sample_valid <= 1'b1;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_ask > 0)
        begin
            hold_left = hold_ask;
            hold_ask = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        bit      out_taken;
        if (rst_n)
        begin
            in_taken = sample_valid && !sample_stall;
            out_taken = result_valid && !result_stall;
            if (in_taken)
                pending_results.push_back(predict_tick(sample));
            if (out_taken)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no tick outstanding");
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.write_width !== want.write_width)
                    begin
                        $error("write_width: expected %0d, got %0d",
                               want.write_width, result.write_width);
                        failures++;
                    end
                    if (result.pulse_width !== want.pulse_width)
                    begin
                        $error("pulse_width: expected %0d, got %0d",
                               want.pulse_width, result.pulse_width);
                        failures++;
                    end
                    if (result.arrived !== want.arrived)
                    begin
                        $error("arrived: expected %0d, got %0d", want.arrived, result.arrived);
                        failures++;
                    end
                    if (result.safety_stop !== want.safety_stop)
                    begin
                        $error("safety_stop: expected %0d, got %0d",
                               want.safety_stop, result.safety_stop);
                        failures++;
                    end
                end
            end
            if (in_taken || out_taken || (psel && penable && pwrite))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        ctl_cfg.safe_high = RST_SAFE_HIGH;
        ctl_cfg.safe_low = RST_SAFE_LOW;
        ctl_cfg.arrive_tolerance = RST_ARRIVE_TOL;
        ctl_cfg.still_tolerance = RST_STILL_TOL;
        ctl_cfg.min_fwd_width = RST_MIN_FWD_WIDTH;
        ctl_cfg.min_back_width = RST_MIN_BACK_WIDTH;
        ctl_cfg.max_fwd_width = RST_MAX_FWD_WIDTH;
        ctl_cfg.max_back_width = RST_MAX_BACK_WIDTH;
        last_pos = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 83;

        // Safety window edges, just inside and just past each limit.
        push_tick(0, 0);
        push_tick(99, 500);
        push_tick(100, 1023);
        push_tick(924, 0);
        push_tick(925, 0);
        push_tick(1023, 1023);
        // Arrival at the edges of both tolerances, and just past them.
        push_tick(500, 500);
        push_tick(503, 507);
        push_tick(505, 495);
        push_tick(506, 495);
        push_tick(511, 506);
        // Forward and backward deadband lift, at and around its edges.
        push_tick(550, 500);
        push_tick(555, 500);
        push_tick(749, 500);
        push_tick(750, 500);
        push_tick(450, 500);
        push_tick(449, 500);
        push_tick(300, 500);
        push_tick(250, 500);
        // Negative offsets round toward minus infinity.
        push_tick(499, 500);
        push_tick(494, 520);
        push_tick(512, 1023);
        push_tick(923, 924);
        wait_drained();

        push_random_ticks(60);
        wait_drained();
        push_random_ticks(60);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 12;

        // Widest window, lift that overshoots the clamp.
        write_reg(REG_SAFE_HIGH, 1023);
        write_reg(REG_SAFE_LOW, 0);
        write_reg(REG_ARRIVE_TOL, 1023);
        write_reg(REG_STILL_TOL, 0);
        write_reg(REG_MIN_FWD_WIDTH, 2047);
        write_reg(REG_MIN_BACK_WIDTH, 0);
        write_reg(REG_MAX_FWD_WIDTH, 1600);
        write_reg(REG_MAX_BACK_WIDTH, 1400);
        push_random_ticks(100);
        wait_drained();

        // Crossed safety limits: every sample stops, the high test winning where both apply.
        write_reg(REG_SAFE_HIGH, 0);
        write_reg(REG_SAFE_LOW, 1023);
        write_reg(REG_ARRIVE_TOL, 0);
        write_reg(REG_STILL_TOL, 1023);
        write_reg(REG_MIN_FWD_WIDTH, 1000);
        write_reg(REG_MIN_BACK_WIDTH, 2000);
        push_random_ticks(40);
        wait_drained();

        // Crossed clamps and deadband limits that never lift.
        write_reg(REG_SAFE_HIGH, 1023);
        write_reg(REG_SAFE_LOW, 0);
        write_reg(REG_MIN_FWD_WIDTH, 0);
        write_reg(REG_MIN_BACK_WIDTH, 2047);
        write_reg(REG_MAX_FWD_WIDTH, 1500);
        write_reg(REG_MAX_BACK_WIDTH, 1600);
        push_random_ticks(40);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        for (int k = 0; k < 3; k++)
        begin
            write_reg(REG_SAFE_HIGH, $urandom_range(700, 1023));
            write_reg(REG_SAFE_LOW, $urandom_range(0, 300));
            write_reg(REG_ARRIVE_TOL, $urandom_range(0, 60));
            write_reg(REG_STILL_TOL, $urandom_range(0, 30));
            write_reg(REG_MIN_FWD_WIDTH, $urandom_range(1500, 1700));
            write_reg(REG_MIN_BACK_WIDTH, $urandom_range(1300, 1500));
            write_reg(REG_MAX_FWD_WIDTH, $urandom_range(1550, 2000));
            write_reg(REG_MAX_BACK_WIDTH, $urandom_range(1000, 1450));
            // The first pass starts with the receiver backed up for a long
            // stretch while ticks keep coming, so the input side has to stall.
            if (k == 0)
                hold_ask = LONG_HOLD;
            push_random_ticks(110);
            wait_drained();
        end

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
src/sppc_pkg.sv
src/sppc_regs.sv
src/sppc_calc.sv
src/servo_position_p_controller_unit.sv
tb/sv/testbench.sv
